@@ rtl/evos_pkg.sv @@
// ----------------------------------------------------------------------------
// evos_pkg: shared types and constants for the euler velocity/offset step
// widths of the item fields, queue depth default and the front-to-back item
// ----------------------------------------------------------------------------
package evos_pkg;

    localparam int DT_W           = 21;
    localparam int CW_W           = 32;
    localparam int IN_DATA_W      = 216;
    localparam int OUT_DATA_W     = 192;
    localparam int FIFO_DEPTH_DEF = 4;

    // item after the velocity update, as it waits in the queue
    typedef struct packed {
        logic [2:0][CW_W-1:0] nv;
        logic [2:0][CW_W-1:0] acc;
        logic [DT_W-1:0]      dt;
        logic                 nv_zero;
    } front_item_t;

endpackage

@@ rtl/evos_front.sv @@
// ----------------------------------------------------------------------------
// evos_front: input stage
// takes input transfers, forms the saturated new velocity and flags zero vectors
// ----------------------------------------------------------------------------
module evos_front
    import evos_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  q_valid,
    input  logic                  q_ready,
    output front_item_t           q_item
);

    logic        f_vld_reg;
    logic        f_vld_next;
    front_item_t f_item_reg;
    front_item_t f_item_next;

    logic signed [53:0] prod   [3];
    logic signed [53:0] rnd    [3];
    logic signed [53:0] sum    [3];

    assign s_axis_tready = !f_vld_reg || q_ready;
    assign q_valid       = f_vld_reg;
    assign q_item        = f_item_reg;

    always_comb
    begin
        f_item_next.dt = s_axis_tdata[DT_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            f_item_next.acc[i] = s_axis_tdata[117 + 32*i +: 32];
            prod[i] = $signed(s_axis_tdata[117 + 32*i +: 32])
                      * $signed({1'b0, s_axis_tdata[DT_W-1:0]});
            rnd[i]  = (prod[i] + 54'sd32768) >>> 16;
            sum[i]  = $signed(s_axis_tdata[21 + 32*i +: 32]) + rnd[i];
            // clamp to the signed 32 bit range
            if (sum[i] > 54'sh7FFFFFFF)
                f_item_next.nv[i] = 32'h7FFFFFFF;
            else if (sum[i] < -54'sh80000000)
                f_item_next.nv[i] = 32'h80000000;
            else
                f_item_next.nv[i] = sum[i][31:0];
        end
        f_item_next.nv_zero = (f_item_next.nv == '0);
    end

    assign f_vld_next = s_axis_tvalid ? 1'b1 : (f_vld_reg && !q_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (s_axis_tready)
            f_vld_reg <= f_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            f_item_reg <= f_item_next;
    end

endmodule

@@ rtl/evos_fifo.sv @@
// ----------------------------------------------------------------------------
// evos_fifo: short queue between front and back
// register array with read and write pointers and a fill count
// ----------------------------------------------------------------------------
module evos_fifo
    import evos_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF,
    parameter int WIDTH = $bits(front_item_t)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_valid,
    output logic                         wr_ready,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic                         rd_en,
    output logic                         rd_valid,
    output logic [WIDTH-1:0]             rd_data,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    wp_next;
    logic [AW-1:0]    rp_reg;
    logic [AW-1:0]    rp_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic             push;
    logic             pop;

    assign wr_ready = (cnt_reg != CW'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rp_reg];
    assign count    = cnt_reg;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_en && rd_valid;

    always_comb
    begin
        wp_next  = (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
        rp_next  = (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_next;
            if (pop)
                rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wr_data;
    end

endmodule

@@ rtl/evos_back.sv @@
// ----------------------------------------------------------------------------
// evos_back: arithmetic pipeline
// squares, two pipelined square roots, distance, three pipelined dividers
// and the final direction scaling, stalled as a whole by the output side
// ----------------------------------------------------------------------------
module evos_back
    import evos_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  front_item_t            q_item,
    output logic                   q_pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int NS     = 69;
    localparam int SQ_N   = 32;
    localparam int DIV_N  = 31;
    localparam int S_LEN  = 2 + SQ_N;   // lengths ready
    localparam int S_DQ   = S_LEN + 2;  // distance ready, divider start
    localparam int S_DIV  = S_DQ + DIV_N;

    typedef struct packed {
        logic [2:0][31:0] nv;
        logic [2:0][31:0] mag;
        logic [DT_W-1:0]  dt;
        logic [25:0]      dt2;
        logic [31:0]      lv;
        logic [42:0]      dq;
        logic             zero;
    } carry_t;

    function automatic logic [127:0] sq_step(input logic [63:0] x, input logic [63:0] r,
                                              input int k);
        logic [63:0] b;
        logic [63:0] t;
        begin
            b = 64'd1 << (62 - 2*k);
            t = r + b;
            if (x >= t)
                sq_step = {x - t, (r >> 1) + b};
            else
                sq_step = {x, r >> 1};
        end
    endfunction

    logic         en;
    logic         vld_reg [1:NS];
    carry_t       cr_reg  [1:NS];
    carry_t       c1_next;
    carry_t       len_item;
    carry_t       dq_item;
    logic [63:0]  sqv_reg [3];
    logic [63:0]  sqa_reg [3];
    logic [63:0]  sqv_next [3];
    logic [63:0]  sqa_next [3];
    logic [31:0]  amag    [3];
    logic [41:0]  dtsq;
    logic [63:0]  sxv_reg [0:SQ_N];
    logic [63:0]  srv_reg [0:SQ_N];
    logic [63:0]  sxa_reg [0:SQ_N];
    logic [63:0]  sra_reg [0:SQ_N];
    logic [52:0]  pv_reg;
    logic [57:0]  pa_reg;
    logic [57:0]  dist_sum;
    logic [31:0]  rem_reg [0:DIV_N][3];
    logic [30:0]  quo_reg [0:DIV_N][3];
    logic [52:0]  hi_reg  [3];
    logic [51:0]  lo_reg  [3];
    logic [31:0]  off_reg [3];
    logic [31:0]  off_next [3];
    logic [63:0]  rsum    [3];

    assign en            = !vld_reg[NS] || m_axis_tready;
    assign q_pop         = en && q_valid;
    assign m_axis_tvalid = vld_reg[NS];
    assign m_axis_tdata  = {off_reg[2], off_reg[1], off_reg[0],
                            cr_reg[NS].nv[2], cr_reg[NS].nv[1], cr_reg[NS].nv[0]};

    // magnitudes and squares
    always_comb
    begin
        c1_next      = '0;
        c1_next.nv   = q_item.nv;
        c1_next.dt   = q_item.dt;
        c1_next.zero = q_item.nv_zero;
        dtsq         = 42'(q_item.dt) * 42'(q_item.dt);
        c1_next.dt2  = 26'((dtsq + 42'd32768) >> 16);
        for (int i = 0; i < 3; i++)
        begin
            c1_next.mag[i] = q_item.nv[i][31] ? (~q_item.nv[i] + 32'd1) : q_item.nv[i];
            amag[i]        = q_item.acc[i][31] ? (~q_item.acc[i] + 32'd1) : q_item.acc[i];
            sqv_next[i]    = 64'(c1_next.mag[i]) * 64'(c1_next.mag[i]);
            sqa_next[i]    = 64'(amag[i]) * 64'(amag[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= NS; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= q_valid;
            for (int s = 2; s <= NS; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    assign dist_sum = 58'(pv_reg) + (pa_reg >> 1);

    // carry items that pick up the length and the rounded distance
    always_comb
    begin
        len_item    = cr_reg[S_LEN];
        len_item.lv = srv_reg[SQ_N][31:0];
        dq_item     = cr_reg[S_DQ-1];
        dq_item.dq  = 43'((dist_sum + 58'd32768) >> 16);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cr_reg[1] <= c1_next;
            for (int s = 2; s <= NS; s++)
            begin
                if (s == S_LEN + 1)
                    cr_reg[s] <= len_item;
                else if (s == S_DQ)
                    cr_reg[s] <= dq_item;
                else
                    cr_reg[s] <= cr_reg[s-1];
            end

            for (int i = 0; i < 3; i++)
            begin
                sqv_reg[i] <= sqv_next[i];
                sqa_reg[i] <= sqa_next[i];
            end

            // square roots, one result bit per stage
            sxv_reg[0] <= sqv_reg[0] + sqv_reg[1] + sqv_reg[2];
            sxa_reg[0] <= sqa_reg[0] + sqa_reg[1] + sqa_reg[2];
            srv_reg[0] <= '0;
            sra_reg[0] <= '0;
            for (int k = 0; k < SQ_N; k++)
            begin
                {sxv_reg[k+1], srv_reg[k+1]} <= sq_step(sxv_reg[k], srv_reg[k], k);
                {sxa_reg[k+1], sra_reg[k+1]} <= sq_step(sxa_reg[k], sra_reg[k], k);
            end

            // distance products
            pv_reg <= 53'(srv_reg[SQ_N][31:0]) * 53'(cr_reg[S_LEN].dt);
            pa_reg <= 58'(sra_reg[SQ_N][31:0]) * 58'(cr_reg[S_LEN].dt2);

            // restoring division, one quotient bit per stage
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= cr_reg[S_DQ-1].mag[i] >> 1;
                quo_reg[0][i] <= '0;
                for (int s = 1; s <= DIV_N; s++)
                begin
                    if ({rem_reg[s-1][i], (s == 1) ? cr_reg[S_DQ-1+s].mag[i][0] : 1'b0}
                        >= {1'b0, cr_reg[S_DQ-1+s].lv})
                    begin
                        rem_reg[s][i] <= 32'({rem_reg[s-1][i],
                                              (s == 1) ? cr_reg[S_DQ-1+s].mag[i][0] : 1'b0}
                                             - {1'b0, cr_reg[S_DQ-1+s].lv});
                        quo_reg[s][i] <= {quo_reg[s-1][i][29:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[s][i] <= {rem_reg[s-1][i][30:0],
                                          (s == 1) ? cr_reg[S_DQ-1+s].mag[i][0] : 1'b0};
                        quo_reg[s][i] <= {quo_reg[s-1][i][29:0], 1'b0};
                    end
                end
                hi_reg[i]  <= 53'(quo_reg[DIV_N][i]) * 53'(cr_reg[S_DIV].dq[42:21]);
                lo_reg[i]  <= 52'(quo_reg[DIV_N][i]) * 52'(cr_reg[S_DIV].dq[20:0]);
                off_reg[i] <= off_next[i];
            end
        end
    end

    // rounding, sign and saturation of the offset
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rsum[i] = ({hi_reg[i][40:0], 21'b0} + 64'(lo_reg[i]) + 64'd536870912) >> 30;
            if (cr_reg[NS-1].zero)
                off_next[i] = '0;
            else if (hi_reg[i] >= 53'd2199023255552 || rsum[i] >= 64'h80000000)
                off_next[i] = cr_reg[NS-1].nv[i][31] ? 32'h80000000 : 32'h7FFFFFFF;
            else if (cr_reg[NS-1].nv[i][31])
                off_next[i] = ~rsum[i][31:0] + 32'd1;
            else
                off_next[i] = rsum[i][31:0];
        end
    end

endmodule

@@ rtl/euler_velocity_offset_step.sv @@
// ----------------------------------------------------------------------------
// euler_velocity_offset_step: explicit euler step on q16.16 3d vectors
// new velocity v + a*dt and offset along it of |vn|*dt + |a|*dt^2/2
// ----------------------------------------------------------------------------
// usage
//   input stream s_axis: one transfer per entity with time step, velocity and
//   acceleration; output stream m_axis: one transfer per input with the new
//   velocity and the offset, in input order
//   throughput: one item per cycle, sustained while m_axis_tready is high
//   path: between input transfer and output valid lie the front stage, the
//   queue, 32 square root stages, 31 divider stages and the multiply stages
//   around them
//   reset: rst_n clears the front register, the queue count and all pipeline
//   valid bits; no item is in flight afterwards
//   stall: when the receiver holds tready low the whole back pipeline holds,
//   the queue fills behind it and s_axis_tready drops only once the queue and
//   the front register are full; nothing is lost or repeated
//   zero new velocity gives zero offsets; overflow saturates to 32 bits
// ----------------------------------------------------------------------------
module euler_velocity_offset_step
    import evos_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // step_time[20:0], vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, 3 zero bits
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // new_vel_x, new_vel_y, new_vel_z, offset_x, offset_y, offset_z
    output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int CNT_W = $clog2(FIFO_DEPTH+1);

    logic              f_valid;
    logic              f_ready;
    front_item_t       f_item;
    logic              b_valid;
    front_item_t       b_item;
    logic              b_pop;
    logic [CNT_W-1:0]  q_count;

    // front: velocity update and zero check
    evos_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_valid       (f_valid),
        .q_ready       (f_ready),
        .q_item        (f_item)
    );

    // queue decouples the front from the stallable back pipeline
    evos_fifo #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH ($bits(front_item_t))
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_item),
        .rd_en    (b_pop),
        .rd_valid (b_valid),
        .rd_data  (b_item),
        .count    (q_count)
    );

    // back: lengths, distance, direction and output register
    evos_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (b_valid),
        .q_item        (b_item),
        .q_pop         (b_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // input side only stalls once the queue is full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> q_count == CNT_W'(FIFO_DEPTH))
        else $error("input stalled with room in the queue");

    // back never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        b_pop |-> q_count != '0)
        else $error("pop from empty queue");

    // zero velocity result carries zero offsets
    a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[95:0] == '0) |-> m_axis_tdata[191:96] == '0)
        else $error("nonzero offset for zero velocity");

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for euler_velocity_offset_step
// streams directed and random entities through the block, predicts every
// result in the bench, checks the results in order, stalls both sides
// ----------------------------------------------------------------------------
module testbench
    import evos_pkg::*;
();

    typedef struct packed {
        logic [31:0] off_z, off_y, off_x, nv_z, nv_y, nv_x;
    } step_result_t;

    localparam int RANDOM_N   = 600;
    localparam int HOLD_AT    = 150;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 120;
    localparam int CYCLE_LIMIT = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [IN_DATA_W-1:0] entity_queue [$];
    step_result_t         result_queue [$];
    int                   fail_count = 0;
    int                   sent_count = 0;
    int                   recv_count = 0;
    int                   zero_vel_count = 0;
    int                   cycle_count = 0;
    int                   send_gap = 0;
    int                   recv_gap = 0;
    int                   hold_left = 0;
    bit                   hold_done = 1'b0;

    euler_velocity_offset_step u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [IN_DATA_W-1:0] pack_entity(logic [20:0] dt,
        logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
        logic [31:0] ax, logic [31:0] ay, logic [31:0] az);
        return {3'b000, az, ay, ax, vz, vy, vx, dt};
    endfunction

    // floor(sqrt(x^2 + y^2 + z^2)) by the digit-by-digit method
    function automatic bit [63:0] vec_length(longint c0, longint c1, longint c2);
        bit [63:0] sum;
        bit [63:0] root;
        bit [63:0] one;
        bit [63:0] m0, m1, m2;
        m0 = c0 < 0 ? -c0 : c0;
        m1 = c1 < 0 ? -c1 : c1;
        m2 = c2 < 0 ? -c2 : c2;
        sum = m0 * m0 + m1 * m1 + m2 * m2;
        root = 0;
        one = 64'd1 << 62;
        while (one > sum)
            one = one >> 2;
        while (one != 0)
        begin
            if (sum >= root + one)
            begin
                sum = sum - (root + one);
                root = (root >> 1) + one;
            end
            else
                root = root >> 1;
            one = one >> 2;
        end
        return root;
    endfunction

    function automatic step_result_t euler_predict(logic [IN_DATA_W-1:0] d);
        longint       dt;
        longint       vel [3];
        longint       acc [3];
        longint       nvel [3];
        longint       off [3];
        longint       prod;
        bit [63:0]    len_v, len_a, dt_sq, travel, dist_q, unit, hi, lo, r, mg;
        step_result_t res;
        dt = longint'(d[20:0]);
        for (int i = 0; i < 3; i++)
        begin
            vel[i] = longint'(signed'(d[21 + 32*i +: 32]));
            acc[i] = longint'(signed'(d[117 + 32*i +: 32]));
            prod = (acc[i] * dt + 32768) >>> 16;
            nvel[i] = vel[i] + prod;
            if (nvel[i] > 64'sh7FFFFFFF)
                nvel[i] = 64'sh7FFFFFFF;
            else if (nvel[i] < -64'sh80000000)
                nvel[i] = -64'sh80000000;
        end
        len_v = vec_length(nvel[0], nvel[1], nvel[2]);
        len_a = vec_length(acc[0], acc[1], acc[2]);
        dt_sq = (dt * dt + 32768) >> 16;
        travel = len_v * dt + ((len_a * dt_sq) >> 1);
        dist_q = (travel + 32768) >> 16;
        for (int i = 0; i < 3; i++)
        begin
            if (len_v == 0)
                off[i] = 0;
            else
            begin
                mg = nvel[i] < 0 ? -nvel[i] : nvel[i];
                unit = (mg << 30) / len_v;
                hi = unit * (dist_q >> 21);
                lo = unit * (dist_q & 64'h1FFFFF);
                if (hi >= (64'd1 << 41))
                    off[i] = nvel[i] < 0 ? -64'sh80000000 : 64'sh7FFFFFFF;
                else
                begin
                    r = ((hi << 21) + lo + (64'd1 << 29)) >> 30;
                    if (r > 64'h80000000)
                        r = 64'h80000000;
                    off[i] = nvel[i] < 0 ? -longint'(r) : longint'(r);
                    if (off[i] > 64'sh7FFFFFFF)
                        off[i] = 64'sh7FFFFFFF;
                end
            end
        end
        res.nv_x  = nvel[0][31:0];
        res.nv_y  = nvel[1][31:0];
        res.nv_z  = nvel[2][31:0];
        res.off_x = off[0][31:0];
        res.off_y = off[1][31:0];
        res.off_z = off[2][31:0];
        return res;
    endfunction

    // random component: mostly moderate values, some full range
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            2: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
            default: return 32'($urandom_range(0, 2048)) - 32'd1024;
        endcase
    endfunction

    // stimulus: directed corners, then random entities
    initial
    begin
        logic [20:0] dt;
        logic [31:0] vx, vy, vz;
        // all zero, zero step
        entity_queue.push_back(pack_entity(0, 0, 0, 0, 0, 0, 0));
        // zero step keeps velocity, zero acceleration
        entity_queue.push_back(pack_entity(0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                                           0, 0, 0));
        // step of 16.0, extreme positive and negative saturation
        entity_queue.push_back(pack_entity(21'h100000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                           32'h7FFF_FFFF));
        entity_queue.push_back(pack_entity(21'h100000, 32'h8000_0000, 32'h8000_0000,
                                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                           32'h8000_0000));
        // velocity cancelled by acceleration: zero new velocity
        entity_queue.push_back(pack_entity(21'h010000, 32'hFFFF_0000, 32'h0002_0000, 0,
                                           32'h0001_0000, 32'hFFFE_0000, 0));
        // zero new velocity with zero acceleration
        entity_queue.push_back(pack_entity(21'h1FFFF, 0, 0, 0, 0, 0, 0));
        // mixed signs with one step
        entity_queue.push_back(pack_entity(21'h010000, 32'h0003_0000, 32'hFFFC_0000,
                                           32'h0000_8000, 32'h8000_0000, 32'h7FFF_FFFF, 1));
        // a single axis, offset near full scale
        entity_queue.push_back(pack_entity(21'h0FFFFF, 32'h7FFF_0000, 0, 0, 0, 0, 0));
        entity_queue.push_back(pack_entity(21'h100000, 0, 0, 32'h8000_0000, 0, 0, 0));
        // tiny step and values, rounding; then alternating bit patterns
        entity_queue.push_back(pack_entity(21'h000001, 1, 32'hFFFF_FFFF, 0,
                                           32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_FFFF));
        entity_queue.push_back(pack_entity(21'h0AAAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                           32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                           32'hAAAA_AAAA));
        entity_queue.push_back(pack_entity(21'h155555, 32'hAAAA_AAAA, 32'h5555_5555,
                                           32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                           32'h5555_5555));
        for (int n = 0; n < RANDOM_N; n++)
        begin
            case ($urandom_range(0, 4))
                0: dt = 21'($urandom_range(0, 21'h100000));
                1: dt = 21'($urandom_range(0, 21'h003000));
                default: dt = 21'($urandom_range(0, 21'h020000));
            endcase
            vx = rand_comp();
            vy = rand_comp();
            vz = rand_comp();
            entity_queue.push_back(pack_entity(dt, vx, vy, vz,
                                               rand_comp(), rand_comp(), rand_comp()));
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (entity_queue.size() == 0 && !s_axis_tvalid);
        wait (result_queue.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (result_queue.size() != 0)
            fail_count++;
        $display("covered %0d entities (%0d with zero new velocity), %0d results checked",
                 sent_count, zero_vel_count, recv_count);
        $display("input and output idling, one long output hold-off of %0d cycles",
                 HOLD_LEN);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // driver: offer queued entities, random gap after each transfer in alternate stretches of 100
    always @(posedge clk)
    begin
        logic       busy;
        logic       next_valid;
        step_result_t exp_res;
        if (rst_n)
        begin
            busy = s_axis_tvalid;
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                exp_res = euler_predict(s_axis_tdata);
                if (exp_res.nv_x == 0 && exp_res.nv_y == 0 && exp_res.nv_z == 0)
                    zero_vel_count++;
                result_queue.push_back(exp_res);
                void'(entity_queue.pop_front());
                sent_count++;
                busy = 1'b0;
                next_valid = 1'b0;
                // alternate idle and back-to-back stretches
                send_gap = ((sent_count / 100) % 2 == 1) ? $urandom_range(0, 5) : 0;
            end
            if (!busy)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (entity_queue.size() > 0)
                begin
                    s_axis_tdata <= entity_queue[0];
                    next_valid = 1'b1;
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // monitor: check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        step_result_t got, want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                recv_count++;
                if (result_queue.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (got.nv_x != want.nv_x)
                        $display("%0t: new_vel_x exp %h got %h", $time, want.nv_x, got.nv_x);
                    if (got.nv_y != want.nv_y)
                        $display("%0t: new_vel_y exp %h got %h", $time, want.nv_y, got.nv_y);
                    if (got.nv_z != want.nv_z)
                        $display("%0t: new_vel_z exp %h got %h", $time, want.nv_z, got.nv_z);
                    if (got.off_x != want.off_x)
                        $display("%0t: offset_x exp %h got %h", $time, want.off_x, got.off_x);
                    if (got.off_y != want.off_y)
                        $display("%0t: offset_y exp %h got %h", $time, want.off_y, got.off_y);
                    if (got.off_z != want.off_z)
                        $display("%0t: offset_z exp %h got %h", $time, want.off_z, got.off_z);
                    if (got != want)
                        fail_count++;
                end
                recv_gap = ((recv_count / 80) % 2 == 1) ? $urandom_range(0, 5) : 0;
            end
            else if (recv_gap > 0)
                recv_gap--;
            m_axis_tready <= (hold_left == 0 && recv_gap == 0);
        end
    end

    // long receiver hold-off so the block fills and stalls its input
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
                hold_left--;
            else if (!hold_done && recv_count >= HOLD_AT)
            begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
rtl/evos_pkg.sv
rtl/evos_front.sv
rtl/evos_fifo.sv
rtl/evos_back.sv
rtl/euler_velocity_offset_step.sv
bench/testbench.sv
